>>> src/conv7_pkg.sv
// Shared constants, types and codes for the 7x7 convolution block.
`default_nettype none
package conv7_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int KERNEL_SIZE = 7;
    localparam int HALF        = KERNEL_SIZE / 2;
    localparam int LINES       = KERNEL_SIZE - 1;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);

    localparam int PIX_W     = 16;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = PIX_W + COEF_W + 1;
    localparam int ROW_SUM_W = PROD_W + 3;
    localparam int SUM_W     = ROW_SUM_W + 3;
    localparam int COL_SEL_W = 3;

    // input word codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_COEF  = 1'b1;

    // register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_OFFSET = 2'd2;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
    } ls_ctrl_t;

    typedef struct packed {
        logic                 shift;
        logic                 coef_we;
        logic [COL_SEL_W-1:0] coef_col;
    } row_ctrl_t;

endpackage
`default_nettype wire

>>> src/conv7x7_divide_offset.sv
// Top level of the 7x7 convolution with divide by 49 and offset.
//
// Pixel channel (pix_valid / pix_stall): one word per clock while pix_stall
// is low. cmd selects a raster pixel or a kernel coefficient load; loads
// take effect in stream order, so earlier pixels still use the old kernel.
// Result channel (res_valid / res_stall): one word per interior pixel with
// the centre coordinates and a flag on the final interior pixel of a frame.
// Border pixels and coefficient loads give no word.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): width, height
// and offset; always ready, write only while the stream is idle.
// Throughput: one pixel per clock while pix_stall is low, set by the chain
// of six line-store cells (one read and one write port each) and the 7-cell
// window rows. Path: a result word passes the line read, window, products,
// row sums, total, magnitude and reciprocal partial products, then the write
// into the 16-entry output queue, and then shows at res_valid.
// Stall: results queue up; the pixel side stalls only once sixteen results
// are in flight or waiting, so a short result stall never stops input.
// Reset: counters clear, window clears, kernel goes to all ones, registers
// to width 1024, height 1024, offset 2. No clearing pass on the line stores.
`default_nettype none
module conv7x7_divide_offset
    import conv7_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               pix_valid,
    output logic                    pix_stall,
    input  wire logic               cmd,
    input  wire logic        [15:0] pixel,
    input  wire logic        [5:0]  coef_index,
    input  wire logic signed [15:0] coef_value,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic             [15:0] result,
    output logic             [15:0] out_row,
    output logic             [9:0]  out_col,
    output logic                    last_pixel,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic        [1:0]  cfg_index,
    input  wire logic        [15:0] cfg_data
);

    localparam int FIFO_DEPTH = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = PTR_W + 1;
    localparam int LAST_ST    = 8;

    typedef struct packed {
        logic [15:0] row;
        logic [9:0]  col;
        logic        last;
    } meta_t;

    typedef struct packed {
        logic                     load;
        logic [PIX_W-1:0]         pixel;
        logic [ADDR_W-1:0]        addr;
        logic [5:0]               coef_idx;
        logic signed [COEF_W-1:0] coef_val;
        logic                     emit;
        meta_t                    meta;
    } stage_t;

    typedef struct packed {
        logic [15:0] result;
        meta_t       meta;
    } out_word_t;

    // configuration registers
    logic [10:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic [15:0] result_offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= 11'd1024;
            image_height_reg  <= 16'd1024;
            result_offset_reg <= 16'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIDTH:  image_width_reg   <= cfg_data[10:0];
                REG_HEIGHT: image_height_reg  <= cfg_data;
                REG_OFFSET: result_offset_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // raster counters
    logic [ADDR_W-1:0] col_reg, col_next;
    logic [15:0]       row_reg, row_next;
    logic [16:0]       w_lim, h_lim, col_inc, row_inc;
    logic              acc, acc_pix, is_emit, is_last;
    logic [15:0]       col_centre;

    assign acc     = pix_valid && !pix_stall;
    assign acc_pix = acc && (cmd == CMD_PIXEL);

    always_comb
    begin
        w_lim = {6'd0, image_width_reg};
        if (w_lim > 17'(MAX_WIDTH))
        begin
            w_lim = 17'(MAX_WIDTH);
        end
        if (w_lim == 17'd0)
        begin
            w_lim = 17'd1;
        end
        h_lim = {1'b0, image_height_reg};
        if (h_lim == 17'd0)
        begin
            h_lim = 17'd1;
        end
        col_inc = 17'(col_reg) + 17'd1;
        row_inc = {1'b0, row_reg} + 17'd1;
        is_emit = (row_reg >= 16'(LINES)) && (col_reg >= ADDR_W'(LINES));
        is_last = (col_inc == w_lim) && (row_inc == h_lim);
        col_centre = 16'(col_reg) - 16'(HALF);
        col_next = col_reg;
        row_next = row_reg;
        if (acc_pix)
        begin
            if (col_inc >= w_lim)
            begin
                col_next = '0;
                row_next = (row_inc >= h_lim) ? 16'd0 : row_inc[15:0];
            end
            else
            begin
                col_next = col_inc[ADDR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // front stages: 1 line read, 2 window shift and line write, 3 products
    logic   vld_reg [1:3];
    stage_t st_reg  [1:3];
    stage_t st_in;

    always_comb
    begin
        st_in.load      = (cmd == CMD_COEF);
        st_in.pixel     = pixel;
        st_in.addr      = col_reg;
        st_in.coef_idx  = coef_index;
        st_in.coef_val  = coef_value;
        st_in.emit      = is_emit;
        st_in.meta.row  = row_reg - 16'(HALF);
        st_in.meta.col  = col_centre[9:0];
        st_in.meta.last = is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= 3; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[1] <= acc;
            vld_reg[2] <= vld_reg[1];
            vld_reg[3] <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg[1] <= st_in;
        st_reg[2] <= st_reg[1];
        st_reg[3] <= st_reg[2];
    end

    // chain of line-store cells; cell r feeds window row r
    logic [PIX_W-1:0] col_val [KERNEL_SIZE];
    ls_ctrl_t         ls_ctrl;

    always_comb
    begin
        ls_ctrl.rd_en   = vld_reg[1] && !st_reg[1].load;
        ls_ctrl.rd_addr = st_reg[1].addr;
        ls_ctrl.wr_en   = vld_reg[2] && !st_reg[2].load;
        ls_ctrl.wr_addr = st_reg[2].addr;
    end

    assign col_val[KERNEL_SIZE-1] = st_reg[2].pixel;

    for (genvar r = 0; r < LINES; r++)
    begin : g_line
        conv7_line_cell u_cell (
            .clk     (clk),
            .ctrl    (ls_ctrl),
            .wr_data (col_val[r+1]),
            .rd_data (col_val[r])
        );
    end

    // window rows; coefficient loads land in stage 3, in stream order
    logic signed [ROW_SUM_W-1:0] row_sum [KERNEL_SIZE];

    for (genvar r = 0; r < KERNEL_SIZE; r++)
    begin : g_row
        localparam logic [5:0] BASE = 6'(r * KERNEL_SIZE);
        row_ctrl_t row_ctrl;
        logic [5:0] rel;

        assign rel = st_reg[3].coef_idx - BASE;

        always_comb
        begin
            row_ctrl.shift    = vld_reg[2] && !st_reg[2].load;
            row_ctrl.coef_we  = vld_reg[3] && st_reg[3].load
                                && (st_reg[3].coef_idx >= BASE)
                                && (st_reg[3].coef_idx < BASE + 6'(KERNEL_SIZE));
            row_ctrl.coef_col = rel[COL_SEL_W-1:0];
        end

        conv7_tap_row u_row (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (row_ctrl),
            .col_in  (col_val[r]),
            .coef_in (st_reg[3].coef_val),
            .row_sum (row_sum[r])
        );
    end

    // total of the row sums, stage 5 to 6
    logic signed [SUM_W-1:0] sum_reg, sum_next;

    always_comb
    begin
        sum_next = '0;
        for (int r = 0; r < KERNEL_SIZE; r++)
        begin
            sum_next = sum_next + SUM_W'(row_sum[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    logic [15:0] div_result;

    conv7_div49 u_div (
        .clk    (clk),
        .sum    (sum_reg),
        .offset (result_offset_reg),
        .result (div_result)
    );

    // result flags and coordinates follow the arithmetic, stages 4 to 8
    logic  ev_reg   [4:LAST_ST];
    meta_t meta_reg [4:LAST_ST];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 4; s <= LAST_ST; s++)
            begin
                ev_reg[s] <= 1'b0;
            end
        end
        else
        begin
            ev_reg[4] <= vld_reg[3] && !st_reg[3].load && st_reg[3].emit;
            for (int s = 5; s <= LAST_ST; s++)
            begin
                ev_reg[s] <= ev_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        meta_reg[4] <= st_reg[3].meta;
        for (int s = 5; s <= LAST_ST; s++)
        begin
            meta_reg[s] <= meta_reg[s-1];
        end
    end

    // output queue; credits cover every result word in flight
    out_word_t        fifo_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg, fill_next, credit_reg, credit_next;
    logic             push, pop, take;

    assign push = ev_reg[LAST_ST];
    assign pop  = res_valid && !res_stall;
    assign take = acc_pix && is_emit;

    assign pix_stall = (credit_reg == CNT_W'(FIFO_DEPTH));
    assign res_valid = (fill_reg != '0);

    always_comb
    begin
        fill_next   = fill_reg + CNT_W'(push) - CNT_W'(pop);
        credit_next = credit_reg + CNT_W'(take) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            credit_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            fill_reg   <= fill_next;
            credit_reg <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= '{result: div_result, meta: meta_reg[LAST_ST]};
        end
    end

    out_word_t head;
    assign head       = fifo_mem[rd_ptr_reg];
    assign result     = head.result;
    assign out_row    = head.meta.row;
    assign out_col    = head.meta.col;
    assign last_pixel = head.meta.last;

endmodule
`default_nettype wire

>>> src/conv7_line_cell.sv
// One line store of the chain: reads the old column entry, stores the word from the row below in the window.
`default_nettype none
module conv7_line_cell
    import conv7_pkg::*;
(
    input  wire logic             clk,
    input  wire ls_ctrl_t         ctrl,
    input  wire logic [PIX_W-1:0] wr_data,
    output logic      [PIX_W-1:0] rd_data
);

    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            // same column written in this cycle by the item ahead: take the new word
            if (ctrl.wr_en && (ctrl.wr_addr == ctrl.rd_addr))
            begin
                rd_reg <= wr_data;
            end
            else
            begin
                rd_reg <= mem[ctrl.rd_addr];
            end
        end
    end

    assign rd_data = rd_reg;

endmodule
`default_nettype wire

>>> src/conv7_tap_row.sv
// One window row: seven taps, seven coefficients, products and a registered row sum.
`default_nettype none
module conv7_tap_row
    import conv7_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire row_ctrl_t                   ctrl,
    input  wire logic        [PIX_W-1:0]     col_in,
    input  wire logic signed [COEF_W-1:0]    coef_in,
    output logic signed      [ROW_SUM_W-1:0] row_sum
);

    logic        [PIX_W-1:0]     tap_reg  [KERNEL_SIZE];
    logic signed [COEF_W-1:0]    coef_reg [KERNEL_SIZE];
    logic signed [PROD_W-1:0]    prod_reg [KERNEL_SIZE];
    logic signed [ROW_SUM_W-1:0] sum_reg;
    logic signed [ROW_SUM_W-1:0] sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < KERNEL_SIZE; c++)
            begin
                tap_reg[c]  <= '0;
                coef_reg[c] <= COEF_W'(1);
            end
        end
        else
        begin
            if (ctrl.shift)
            begin
                for (int c = 0; c < KERNEL_SIZE - 1; c++)
                begin
                    tap_reg[c] <= tap_reg[c+1];
                end
                tap_reg[KERNEL_SIZE-1] <= col_in;
            end
            if (ctrl.coef_we)
            begin
                coef_reg[ctrl.coef_col] <= coef_in;
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int c = 0; c < KERNEL_SIZE; c++)
        begin
            sum_next = sum_next + ROW_SUM_W'(prod_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < KERNEL_SIZE; c++)
        begin
            prod_reg[c] <= coef_reg[c] * $signed({1'b0, tap_reg[c]});
        end
        sum_reg <= sum_next;
    end

    assign row_sum = sum_reg;

endmodule
`default_nettype wire

>>> src/conv7_div49.sv
// Signed sum divided by 49 toward zero, plus offset, low 16 bits; reciprocal in partial products.
`default_nettype none
module conv7_div49
    import conv7_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic signed [SUM_W-1:0] sum,
    input  wire logic        [15:0]      offset,
    output logic             [15:0]      result
);

    localparam int MAG_W = SUM_W - 2;
    localparam int LO_W  = 19;
    localparam int SHIFT = 43;
    localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'd48) / 64'd49;
    localparam int TOT_W = 76;

    logic             neg_reg, neg2_reg;
    logic [MAG_W-1:0] mag_reg;
    logic [SUM_W-1:0] mag_full;
    logic [37:0]      pp_ll_reg, pp_lh_reg;
    logic [36:0]      pp_hl_reg, pp_hh_reg;
    logic [TOT_W-1:0] tot;
    logic [15:0]      q16, quot16;

    logic [LO_W-1:0] recip_lo, recip_hi;
    assign recip_lo = RECIP[LO_W-1:0];
    assign recip_hi = RECIP[2*LO_W-1:LO_W];

    assign mag_full = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

    always_ff @(posedge clk)
    begin
        neg_reg   <= sum[SUM_W-1];
        mag_reg   <= mag_full[MAG_W-1:0];
        neg2_reg  <= neg_reg;
        pp_ll_reg <= mag_reg[LO_W-1:0] * recip_lo;
        pp_lh_reg <= mag_reg[LO_W-1:0] * recip_hi;
        pp_hl_reg <= mag_reg[MAG_W-1:LO_W] * recip_lo;
        pp_hh_reg <= mag_reg[MAG_W-1:LO_W] * recip_hi;
    end

    always_comb
    begin
        tot = TOT_W'(pp_ll_reg)
            + (TOT_W'(pp_lh_reg) << LO_W)
            + (TOT_W'(pp_hl_reg) << LO_W)
            + (TOT_W'(pp_hh_reg) << (2 * LO_W));
        q16    = tot[SHIFT+15:SHIFT];
        quot16 = neg2_reg ? 16'(-q16) : q16;
        result = quot16 + offset;
    end

endmodule
`default_nettype wire
